### rtl/gda_pkg.sv
// gda_pkg: field widths, codes, adder control struct and calendar helpers
// for the gregorian date arithmetic block. No dependencies.
`default_nettype none
package gda_pkg;

  localparam int MODE_W  = 2;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 23;
  localparam int DIFF_W  = 22;
  localparam int ACC_W   = 25;

  localparam int MIN_YEAR_DEF = 1900;
  localparam int MAX_YEAR_DEF = 9999;

  localparam int DIFF_MAX      = 2 ** DIFF_W - 1;
  localparam int MONTHS        = 12;
  localparam int FEBRUARY      = 2;
  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  localparam int LEAP_STEP     = 4;

  // floor(v / 100) as (v * 5243) >> 19, exact for all 14-bit v
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SH  = 19;
  localparam int PROD_W    = YEAR_W + 13;
  localparam int QUO_W     = PROD_W - RECIP_SH;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB,
    ALU_RSUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e                  op;
    logic signed [ACC_W-1:0]  operand;
  } alu_ctl_t;

  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(RECIP_100);
    return prod[PROD_W-1:RECIP_SH];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [QUO_W-1:0]  q;
    logic [YEAR_W-1:0] hund;
    q    = div100(y);
    hund = YEAR_W'(q) * YEAR_W'(CENTURY);
    return (y[1:0] == 2'b00) && ((y != hund) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // day number of january 1 of year y, elaboration use only
  function automatic int year_start(input int y);
    int p;
    p = y - 1;
    return DAYS_PER_YEAR * p + p / LEAP_STEP - p / CENTURY
           + p / (LEAP_STEP * CENTURY) + 1;
  endfunction

endpackage
`default_nettype wire

### rtl/gda_in_if.sv
// gda_in_if: request channel of the date unit, valid/ready plus two dates,
// mode and day offset. Depends on gda_pkg.
`default_nettype none
interface gda_in_if import gda_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [YEAR_W-1:0]        first_year;
  logic [MONTH_W-1:0]       first_month;
  logic [DAY_W-1:0]         first_day;
  logic [YEAR_W-1:0]        second_year;
  logic [MONTH_W-1:0]       second_month;
  logic [DAY_W-1:0]         second_day;
  logic signed [OFF_W-1:0]  day_offset;

  modport source (
    output valid, mode, first_year, first_month, first_day,
           second_year, second_month, second_day, day_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, first_year, first_month, first_day,
           second_year, second_month, second_day, day_offset,
    output ready
  );
endinterface
`default_nettype wire

### rtl/gda_out_if.sv
// gda_out_if: result channel of the date unit, valid/ready plus moved date,
// day difference and order flags. Depends on gda_pkg.
`default_nettype none
interface gda_out_if import gda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   result_year;
  logic [MONTH_W-1:0]  result_month;
  logic [DAY_W-1:0]    result_day;
  logic [DIFF_W-1:0]   day_difference;
  logic                first_later;
  logic                dates_equal;
  logic                first_earlier;
  logic                clamped;

  modport source (
    output valid, result_year, result_month, result_day, day_difference,
           first_later, dates_equal, first_earlier, clamped,
    input  ready
  );
  modport sink (
    input  valid, result_year, result_month, result_day, day_difference,
           first_later, dates_equal, first_earlier, clamped,
    output ready
  );
endinterface
`default_nettype wire

### rtl/gda_alu.sv
// gda_alu: shared accumulator with one adder for load, add, subtract and
// reverse subtract. Depends on gda_pkg.
`default_nettype none
module gda_alu import gda_pkg::*; (
  input  logic                     clk_i,
  input  alu_ctl_t                 ctl_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] x, y;
  logic                    cin;

  always_comb begin
    x   = acc_q;
    y   = '0;
    cin = 1'b0;
    unique case (ctl_i.op)
      ALU_LOAD: begin
        x = ctl_i.operand;
      end
      ALU_ADD: begin
        y = ctl_i.operand;
      end
      ALU_SUB: begin
        y   = ~ctl_i.operand;
        cin = 1'b1;
      end
      ALU_RSUB: begin
        x   = ctl_i.operand;
        y   = ~acc_q;
        cin = 1'b1;
      end
      default: begin
        y = '0;
      end
    endcase
    acc_d = x + y + ACC_W'(cin);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

### rtl/gregorian_date_arithmetic.sv
// gregorian_date_arithmetic: add/subtract/difference of gregorian dates.
// A move runs a 14-step year search on the shared adder, then a month walk,
// and a clamped move skips both. A new request is taken only in idle, even
// while the previous result waits. Reset clears sequencer and result valid.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_alu.
`default_nettype none
module gregorian_date_arithmetic import gda_pkg::*; #(
  parameter int MIN_YEAR = MIN_YEAR_DEF,
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gda_in_if.sink     in_i,
  gda_out_if.source  out_o
);

  localparam logic signed [ACC_W-1:0] ORD_LO = ACC_W'(year_start(MIN_YEAR));
  localparam logic signed [ACC_W-1:0] ORD_HI = ACC_W'(year_start(MAX_YEAR + 1) - 1);
  localparam logic signed [ACC_W-1:0] DIFF_SAT = ACC_W'(DIFF_MAX);
  localparam logic [YEAR_W-1:0]       MIN_Y = YEAR_W'(MIN_YEAR);
  localparam int                      BIT_W = $clog2(YEAR_W);

  typedef enum logic [4:0] {
    S_IDLE, S_VAL1, S_VAL2,
    S_ORD_MUL, S_ORD_P4, S_ORD_Q, S_ORD_Q4, S_ORD_MON,
    S_SAVE_A, S_DIFF, S_ABS,
    S_OFF, S_RANGE, S_BS_SET, S_BS_CMP, S_REM, S_MON, S_DONE
  } state_e;

  typedef enum logic [1:0] {PH_A, PH_B, PH_SRCH, PH_YEAR} phase_e;

  state_e                  state_q, state_d;
  phase_e                  ph_q, ph_d;
  logic [MODE_W-1:0]       mode_q, mode_d;
  logic [YEAR_W-1:0]       fy_q, fy_d, sy_q, sy_d, wy_q, wy_d, yy_q, yy_d;
  logic [MONTH_W-1:0]      fm_q, fm_d, sm_q, sm_d, wm_q, wm_d;
  logic [DAY_W-1:0]        fd_q, fd_d, sd_q, sd_d, wd_q, wd_d;
  logic signed [OFF_W-1:0] off_q, off_d;
  logic signed [ACC_W-1:0] a_q, a_d, n_q, n_d;
  logic [BIT_W-1:0]        bit_q, bit_d;
  logic [YEAR_W-1:0]       ry_q, ry_d;
  logic [MONTH_W-1:0]      rm_q, rm_d;
  logic [DAY_W-1:0]        rd_q, rd_d;
  logic                    clamp_q, clamp_d;
  logic                    later_q, later_d, eq_q, eq_d, earlier_q, earlier_d;

  logic                    ov_q, ov_d;
  logic [YEAR_W-1:0]       oy_q, oy_d;
  logic [MONTH_W-1:0]      om_q, om_d;
  logic [DAY_W-1:0]        od_q, od_d;
  logic [DIFF_W-1:0]       odiff_q, odiff_d;
  logic                    olater_q, olater_d, oeq_q, oeq_d, oearlier_q, oearlier_d;
  logic                    oclamp_q, oclamp_d;

  alu_ctl_t                ctl;
  logic signed [ACC_W-1:0] acc;

  logic                    diff_mode;
  logic [YEAR_W-1:0]       vy;
  logic [MONTH_W-1:0]      vm;
  logic [DAY_W-1:0]        vd;
  logic                    leap;
  logic                    date_ok;
  logic [YEAR_W-1:0]       p;
  logic [QUO_W-1:0]        q100;
  logic signed [ACC_W-1:0] mlen_ext;
  logic [YEAR_W-1:0]       ytry;
  logic [YEAR_W-1:0]       ynew;

  gda_alu u_alu (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .acc_o (acc)
  );

  assign diff_mode = (mode_q != MODE_ADD) && (mode_q != MODE_SUB);

  // one leap unit, shared by validation, the ordinal steps and the month walk
  always_comb begin
    if (state_q == S_VAL1) begin
      vy = fy_q;
      vm = fm_q;
      vd = fd_q;
    end else if (state_q == S_VAL2) begin
      vy = sy_q;
      vm = sm_q;
      vd = sd_q;
    end else begin
      vy = wy_q;
      vm = wm_q;
      vd = wd_q;
    end
  end

  assign leap     = is_leap(vy);
  assign date_ok  = (vy >= MIN_Y) && (vm >= MONTH_W'(1)) && (vm <= MONTH_W'(MONTHS))
                    && (vd >= DAY_W'(1)) && (vd <= month_len(vm, leap));
  assign p        = wy_q - YEAR_W'(1);
  assign q100     = div100(p);
  assign mlen_ext = ACC_W'(month_len(wm_q, leap));
  assign ytry     = yy_q | (YEAR_W'(1) << bit_q);
  assign ynew     = (acc <= n_q) ? wy_q : yy_q;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    mode_d     = mode_q;
    fy_d       = fy_q;
    fm_d       = fm_q;
    fd_d       = fd_q;
    sy_d       = sy_q;
    sm_d       = sm_q;
    sd_d       = sd_q;
    off_d      = off_q;
    wy_d       = wy_q;
    wm_d       = wm_q;
    wd_d       = wd_q;
    yy_d       = yy_q;
    a_d        = a_q;
    n_d        = n_q;
    bit_d      = bit_q;
    ry_d       = ry_q;
    rm_d       = rm_q;
    rd_d       = rd_q;
    clamp_d    = clamp_q;
    later_d    = later_q;
    eq_d       = eq_q;
    earlier_d  = earlier_q;
    ov_d       = ov_q && !out_o.ready;
    oy_d       = oy_q;
    om_d       = om_q;
    od_d       = od_q;
    odiff_d    = odiff_q;
    olater_d   = olater_q;
    oeq_d      = oeq_q;
    oearlier_d = oearlier_q;
    oclamp_d   = oclamp_q;
    ctl.op      = ALU_HOLD;
    ctl.operand = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          fy_d    = in_i.first_year;
          fm_d    = in_i.first_month;
          fd_d    = in_i.first_day;
          sy_d    = in_i.second_year;
          sm_d    = in_i.second_month;
          sd_d    = in_i.second_day;
          off_d   = in_i.day_offset;
          state_d = S_VAL1;
        end
      end
      S_VAL1: begin
        if (date_ok) begin
          wy_d = fy_q;
          wm_d = fm_q;
          wd_d = fd_q;
        end else begin
          wy_d = MIN_Y;
          wm_d = MONTH_W'(1);
          wd_d = DAY_W'(1);
        end
        ph_d    = PH_A;
        state_d = diff_mode ? S_VAL2 : S_ORD_MUL;
      end
      S_VAL2: begin
        if (!date_ok) begin
          sy_d = MIN_Y;
          sm_d = MONTH_W'(1);
          sd_d = DAY_W'(1);
        end
        state_d = S_ORD_MUL;
      end
      S_ORD_MUL: begin
        ctl.op      = ALU_LOAD;
        ctl.operand = ACC_W'(p) * ACC_W'(DAYS_PER_YEAR);
        state_d     = S_ORD_P4;
      end
      S_ORD_P4: begin
        ctl.op      = ALU_ADD;
        ctl.operand = ACC_W'(p >> 2);
        state_d     = S_ORD_Q;
      end
      S_ORD_Q: begin
        ctl.op      = ALU_SUB;
        ctl.operand = ACC_W'(q100);
        state_d     = S_ORD_Q4;
      end
      S_ORD_Q4: begin
        ctl.op      = ALU_ADD;
        ctl.operand = ACC_W'(q100 >> 2);
        state_d     = S_ORD_MON;
      end
      S_ORD_MON: begin
        ctl.op      = ALU_ADD;
        ctl.operand = ACC_W'(cum_days(wm_q)) + ACC_W'(wd_q)
                      + ACC_W'((wm_q > MONTH_W'(FEBRUARY)) && leap);
        unique case (ph_q)
          PH_A:    state_d = diff_mode ? S_SAVE_A : S_OFF;
          PH_B:    state_d = S_DIFF;
          PH_SRCH: state_d = S_BS_CMP;
          PH_YEAR: state_d = S_REM;
          default: state_d = S_IDLE;
        endcase
      end
      S_SAVE_A: begin
        a_d     = acc;
        wy_d    = sy_q;
        wm_d    = sm_q;
        wd_d    = sd_q;
        ph_d    = PH_B;
        state_d = S_ORD_MUL;
      end
      S_DIFF: begin
        ctl.op      = ALU_SUB;
        ctl.operand = a_q;
        state_d     = S_ABS;
      end
      S_ABS: begin
        later_d   = acc < 0;
        eq_d      = acc == 0;
        earlier_d = acc > 0;
        if (acc < 0) begin
          ctl.op      = ALU_RSUB;
          ctl.operand = '0;
        end
        state_d = S_DONE;
      end
      S_OFF: begin
        ctl.op      = (mode_q == MODE_ADD) ? ALU_ADD : ALU_SUB;
        ctl.operand = ACC_W'(off_q);
        state_d     = S_RANGE;
      end
      S_RANGE: begin
        n_d = acc;
        if ((acc < ORD_LO) || (acc > ORD_HI)) begin
          ry_d    = MIN_Y;
          rm_d    = MONTH_W'(1);
          rd_d    = DAY_W'(1);
          clamp_d = 1'b1;
          state_d = S_DONE;
        end else begin
          clamp_d = 1'b0;
          yy_d    = '0;
          bit_d   = BIT_W'(YEAR_W - 1);
          state_d = S_BS_SET;
        end
      end
      S_BS_SET: begin
        wy_d    = ytry;
        wm_d    = MONTH_W'(1);
        wd_d    = DAY_W'(1);
        ph_d    = PH_SRCH;
        state_d = S_ORD_MUL;
      end
      S_BS_CMP: begin
        yy_d = ynew;
        if (bit_q == '0) begin
          wy_d    = ynew;
          wm_d    = MONTH_W'(1);
          wd_d    = DAY_W'(1);
          ph_d    = PH_YEAR;
          state_d = S_ORD_MUL;
        end else begin
          bit_d   = bit_q - BIT_W'(1);
          state_d = S_BS_SET;
        end
      end
      S_REM: begin
        ctl.op      = ALU_RSUB;
        ctl.operand = n_q;
        state_d     = S_MON;
      end
      S_MON: begin
        if ((wm_q < MONTH_W'(MONTHS)) && (acc >= mlen_ext)) begin
          ctl.op      = ALU_SUB;
          ctl.operand = mlen_ext;
          wm_d        = wm_q + MONTH_W'(1);
        end else begin
          ry_d    = wy_q;
          rm_d    = wm_q;
          rd_d    = acc[DAY_W-1:0] + DAY_W'(1);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          if (diff_mode) begin
            oy_d       = '0;
            om_d       = '0;
            od_d       = '0;
            oclamp_d   = 1'b0;
            odiff_d    = (acc > DIFF_SAT) ? DIFF_SAT[DIFF_W-1:0] : acc[DIFF_W-1:0];
            olater_d   = later_q;
            oeq_d      = eq_q;
            oearlier_d = earlier_q;
          end else begin
            oy_d       = ry_q;
            om_d       = rm_q;
            od_d       = rd_q;
            oclamp_d   = clamp_q;
            odiff_d    = '0;
            olater_d   = 1'b0;
            oeq_d      = 1'b0;
            oearlier_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      ov_q       <= ov_d;
      ph_q       <= ph_d;
      mode_q     <= mode_d;
      fy_q       <= fy_d;
      fm_q       <= fm_d;
      fd_q       <= fd_d;
      sy_q       <= sy_d;
      sm_q       <= sm_d;
      sd_q       <= sd_d;
      off_q      <= off_d;
      wy_q       <= wy_d;
      wm_q       <= wm_d;
      wd_q       <= wd_d;
      yy_q       <= yy_d;
      a_q        <= a_d;
      n_q        <= n_d;
      bit_q      <= bit_d;
      ry_q       <= ry_d;
      rm_q       <= rm_d;
      rd_q       <= rd_d;
      clamp_q    <= clamp_d;
      later_q    <= later_d;
      eq_q       <= eq_d;
      earlier_q  <= earlier_d;
      oy_q       <= oy_d;
      om_q       <= om_d;
      od_q       <= od_d;
      odiff_q    <= odiff_d;
      olater_q   <= olater_d;
      oeq_q      <= oeq_d;
      oearlier_q <= oearlier_d;
      oclamp_q   <= oclamp_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.result_year    = oy_q;
  assign out_o.result_month   = om_q;
  assign out_o.result_day     = od_q;
  assign out_o.day_difference = odiff_q;
  assign out_o.first_later    = olater_q;
  assign out_o.dates_equal    = oeq_q;
  assign out_o.first_earlier  = oearlier_q;
  assign out_o.clamped        = oclamp_q;

endmodule
`default_nettype wire

### rtl/gda_checker.sv
// gda_checker: port-level assertions for gregorian_date_arithmetic, with the
// bind that attaches it. Depends on gda_pkg and the top level.
`default_nettype none
module gda_checker import gda_pkg::*; #(
  parameter int MIN_YEAR = MIN_YEAR_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [YEAR_W-1:0]   result_year_i,
  input logic [MONTH_W-1:0]  result_month_i,
  input logic [DAY_W-1:0]    result_day_i,
  input logic [DIFF_W-1:0]   day_difference_i,
  input logic                first_later_i,
  input logic                dates_equal_i,
  input logic                first_earlier_i,
  input logic                clamped_i
);

  logic [2:0] flags;
  assign flags = {first_later_i, dates_equal_i, first_earlier_i};

  // busy right after a request transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in progress");

  // a result is either a compare result or a moved date, never a mix
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ($onehot(flags) && result_year_i == '0 && result_month_i == '0
       && result_day_i == '0 && !clamped_i)
      || (flags == 3'b000 && day_difference_i == '0 && result_month_i >= 4'd1
          && result_month_i <= 4'd12 && result_day_i >= 5'd1))
    else $error("malformed result");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clamped_i |->
      result_year_i == YEAR_W'(MIN_YEAR) && result_month_i == 4'd1 && result_day_i == 5'd1)
    else $error("clamped result is not the minimum date");

  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dates_equal_i |-> day_difference_i == '0)
    else $error("equal dates with nonzero difference");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_year_i)
      && $stable(result_month_i) && $stable(result_day_i) && $stable(day_difference_i)
      && $stable(flags) && $stable(clamped_i))
    else $error("stalled result changed");

endmodule

bind gregorian_date_arithmetic gda_checker #(.MIN_YEAR(MIN_YEAR)) u_gda_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_year_i    (out_o.result_year),
  .result_month_i   (out_o.result_month),
  .result_day_i     (out_o.result_day),
  .day_difference_i (out_o.day_difference),
  .first_later_i    (out_o.first_later),
  .dates_equal_i    (out_o.dates_equal),
  .first_earlier_i  (out_o.first_earlier),
  .clamped_i        (out_o.clamped)
);
`default_nettype wire

### bench/tb_gregorian_date_arithmetic.sv
// tb_gregorian_date_arithmetic: self-checking bench for the gregorian date unit,
// predicting every result from the two dates, mode and offset and comparing field by field.
// Depends on gda_pkg, gda_in_if, gda_out_if and gregorian_date_arithmetic.
`default_nettype none
module tb_gregorian_date_arithmetic import gda_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_DIFF   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint LO_YEAR     = MIN_YEAR_DEF;
  localparam longint HI_YEAR     = MAX_YEAR_DEF;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     SETTLE_CYCLES = 300;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [YEAR_W-1:0]       first_year;
    logic [MONTH_W-1:0]      first_month;
    logic [DAY_W-1:0]        first_day;
    logic [YEAR_W-1:0]       second_year;
    logic [MONTH_W-1:0]      second_month;
    logic [DAY_W-1:0]        second_day;
    logic signed [OFF_W-1:0] day_offset;
  } date_req_t;

  typedef struct {
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic [DIFF_W-1:0]  day_difference;
    logic               first_later;
    logic               dates_equal;
    logic               first_earlier;
    logic               clamped;
  } date_res_t;

  logic clk_i;
  logic rst_ni;

  gda_in_if  in_if ();
  gda_out_if out_if ();

  gregorian_date_arithmetic u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  date_res_t expected_dates_q[$];
  int        error_count;
  int        cycle_count;
  int        hold_off_cycles;
  bit        src_idle_en;
  bit        sink_idle_en;

  // calendar predictor
  function automatic bit leap_cal(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(input longint y, input longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_cal(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // day 1 is january 1 of year 1
  function automatic longint day_number(input longint y, input longint m, input longint d);
    longint p;
    longint n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (longint k = 1; k < m; k++) n += days_in_month(y, k);
    return n + d;
  endfunction

  function automatic void repair_date(input logic [YEAR_W-1:0] yi,
                                      input logic [MONTH_W-1:0] mi,
                                      input logic [DAY_W-1:0] di,
                                      output longint y, m, d);
    if (yi >= LO_YEAR && mi >= 1 && mi <= MONTHS && di >= 1
        && di <= days_in_month(yi, mi)) begin
      y = yi;
      m = mi;
      d = di;
    end else begin
      y = LO_YEAR;
      m = 1;
      d = 1;
    end
  endfunction

  function automatic void date_from_day_number(input longint n, output longint y, m, d);
    longint yy;
    longint mm;
    longint rest;
    yy = (n * 400) / 146097;
    if (yy < 1) yy = 1;
    while (day_number(yy + 1, 1, 1) <= n) yy++;
    while (yy > 1 && day_number(yy, 1, 1) > n) yy--;
    rest = n - (day_number(yy, 1, 1) - 1);
    mm = 1;
    while (mm < MONTHS && rest > days_in_month(yy, mm)) begin
      rest -= days_in_month(yy, mm);
      mm++;
    end
    y = yy;
    m = mm;
    d = rest;
  endfunction

  function automatic date_res_t predict_date_result(input date_req_t r);
    date_res_t res;
    longint y1, m1, d1, y2, m2, d2;
    longint a, b, n, gap, ry, rm, rd;
    res = '{default: '0};
    repair_date(r.first_year, r.first_month, r.first_day, y1, m1, d1);
    repair_date(r.second_year, r.second_month, r.second_day, y2, m2, d2);
    a = day_number(y1, m1, d1);
    if (r.mode == MODE_ADD || r.mode == MODE_SUB) begin
      n = (r.mode == MODE_ADD) ? a + longint'(r.day_offset) : a - longint'(r.day_offset);
      if (n < day_number(LO_YEAR, 1, 1) || n > day_number(HI_YEAR, 12, 31)) begin
        ry = LO_YEAR;
        rm = 1;
        rd = 1;
        res.clamped = 1'b1;
      end else begin
        date_from_day_number(n, ry, rm, rd);
      end
      res.result_year  = YEAR_W'(ry);
      res.result_month = MONTH_W'(rm);
      res.result_day   = DAY_W'(rd);
    end else begin
      b = day_number(y2, m2, d2);
      gap = (a > b) ? a - b : b - a;
      if (gap > DIFF_MAX) gap = DIFF_MAX;
      res.day_difference = DIFF_W'(gap);
      res.first_later    = a > b;
      res.dates_equal    = a == b;
      res.first_earlier  = a < b;
    end
    return res;
  endfunction

  function automatic date_req_t date_request(input logic [MODE_W-1:0] mode,
                                             input int y1, input int m1, input int d1,
                                             input int y2, input int m2, input int d2,
                                             input int offset);
    date_req_t r;
    r.mode         = mode;
    r.first_year   = YEAR_W'(y1);
    r.first_month  = MONTH_W'(m1);
    r.first_day    = DAY_W'(d1);
    r.second_year  = YEAR_W'(y2);
    r.second_month = MONTH_W'(m2);
    r.second_day   = DAY_W'(d2);
    r.day_offset   = OFF_W'(offset);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp);
    $display("mismatch on %s at cycle %0d: got %0d expected %0d",
             field, cycle_count, got, exp);
    error_count++;
  endtask

  task automatic check_date_result();
    date_res_t exp;
    if (expected_dates_q.size() == 0) begin
      report_mismatch("unexpected result", 1, 0);
      return;
    end
    exp = expected_dates_q.pop_front();
    if (out_if.result_year !== exp.result_year)
      report_mismatch("result_year", out_if.result_year, exp.result_year);
    if (out_if.result_month !== exp.result_month)
      report_mismatch("result_month", out_if.result_month, exp.result_month);
    if (out_if.result_day !== exp.result_day)
      report_mismatch("result_day", out_if.result_day, exp.result_day);
    if (out_if.day_difference !== exp.day_difference)
      report_mismatch("day_difference", out_if.day_difference, exp.day_difference);
    if (out_if.first_later !== exp.first_later)
      report_mismatch("first_later", out_if.first_later, exp.first_later);
    if (out_if.dates_equal !== exp.dates_equal)
      report_mismatch("dates_equal", out_if.dates_equal, exp.dates_equal);
    if (out_if.first_earlier !== exp.first_earlier)
      report_mismatch("first_earlier", out_if.first_earlier, exp.first_earlier);
    if (out_if.clamped !== exp.clamped)
      report_mismatch("clamped", out_if.clamped, exp.clamped);
  endtask

  task automatic send_date_request(input date_req_t r);
    while (src_idle_en && $urandom_range(0, 99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= r.mode;
    in_if.first_year   <= r.first_year;
    in_if.first_month  <= r.first_month;
    in_if.first_day    <= r.first_day;
    in_if.second_year  <= r.second_year;
    in_if.second_month <= r.second_month;
    in_if.second_day   <= r.second_day;
    in_if.day_offset   <= r.day_offset;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_dates_q.push_back(predict_date_result(r));
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_dates_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void pick_date(output logic [YEAR_W-1:0] y,
                                    output logic [MONTH_W-1:0] m,
                                    output logic [DAY_W-1:0] d);
    int sel;
    int yy;
    int mm;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      y = YEAR_W'($urandom());
      m = MONTH_W'($urandom());
      d = DAY_W'($urandom());
    end else begin
      if (sel < 60) yy = $urandom_range(1900, 2100);
      else if (sel < 92) yy = $urandom_range(1900, 9999);
      else yy = $urandom_range(10000, 16383);
      mm = $urandom_range(1, 12);
      y = YEAR_W'(yy);
      m = MONTH_W'(mm);
      d = DAY_W'($urandom_range(1, int'(days_in_month(yy, mm))));
    end
  endfunction

  function automatic date_req_t random_date_request();
    date_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) r.mode = MODE_ADD;
    else if (sel < 70) r.mode = MODE_SUB;
    else if (sel < 95) r.mode = MODE_DIFF;
    else r.mode = MODE_UNUSED;
    pick_date(r.first_year, r.first_month, r.first_day);
    pick_date(r.second_year, r.second_month, r.second_day);
    sel = $urandom_range(0, 99);
    if (sel < 55) r.day_offset = OFF_W'($urandom_range(0, 800) - 400);
    else if (sel < 85) r.day_offset = OFF_W'($urandom_range(0, 400000) - 200000);
    else r.day_offset = OFF_W'($urandom());
    return r;
  endfunction

  task automatic test_move_extremes();
    send_date_request(date_request(MODE_ADD, 2024, 2, 28, 0, 0, 0, 1));
    send_date_request(date_request(MODE_ADD, 1900, 2, 28, 0, 0, 0, 1));
    send_date_request(date_request(MODE_ADD, 2000, 2, 28, 0, 0, 0, 1));
    send_date_request(date_request(MODE_ADD, 1999, 12, 31, 0, 0, 0, 1));
    send_date_request(date_request(MODE_ADD, 9999, 12, 31, 0, 0, 0, 1));
    send_date_request(date_request(MODE_ADD, 1900, 1, 1, 0, 0, 0, 4194303));
    send_date_request(date_request(MODE_ADD, 2024, 6, 15, 0, 0, 0, -4194304));
    send_date_request(date_request(MODE_SUB, 1900, 1, 1, 0, 0, 0, 1));
    send_date_request(date_request(MODE_SUB, 2000, 3, 1, 0, 0, 0, 1));
    send_date_request(date_request(MODE_SUB, 2024, 1, 1, 0, 0, 0, -366));
    send_date_request(date_request(MODE_SUB, 9999, 12, 31, 0, 0, 0, 0));
    send_date_request(date_request(MODE_ADD, 1900, 1, 1, 0, 0, 0, 2958463));
  endtask

  task automatic test_difference();
    send_date_request(date_request(MODE_DIFF, 2024, 5, 5, 2024, 5, 5, 0));
    send_date_request(date_request(MODE_DIFF, 2024, 5, 6, 2024, 5, 5, 77));
    send_date_request(date_request(MODE_DIFF, 1900, 1, 1, 9999, 12, 31, -1));
    // oversized gap saturates, unused mode code behaves as difference
    send_date_request(date_request(MODE_UNUSED, 16383, 12, 31, 1900, 1, 1, 0));
  endtask

  task automatic test_invalid_dates();
    send_date_request(date_request(MODE_ADD, 0, 0, 0, 0, 0, 0, 10));
    send_date_request(date_request(MODE_ADD, 2023, 2, 29, 0, 0, 0, 0));
    send_date_request(date_request(MODE_ADD, 2024, 4, 31, 0, 0, 0, 0));
    send_date_request(date_request(MODE_ADD, 2024, 0, 10, 0, 0, 0, 5));
    send_date_request(date_request(MODE_ADD, 2024, 15, 31, 0, 0, 0, 5));
    send_date_request(date_request(MODE_ADD, 2024, 3, 0, 0, 0, 0, 5));
    // valid date beyond the top year clamps even with zero offset
    send_date_request(date_request(MODE_ADD, 12000, 6, 15, 0, 0, 0, 0));
    send_date_request(date_request(MODE_DIFF, 2020, 7, 4, 16383, 13, 31, 0));
    send_date_request(date_request(MODE_SUB, 16383, 15, 31, 16383, 15, 31, -1));
  endtask

  task automatic test_random_traffic(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      send_date_request(random_date_request());
    end
  endtask

  task automatic test_backpressure();
    src_idle_en     = 1'b0;
    hold_off_cycles = 600;
    for (int i = 0; i < 6; i++) send_date_request(random_date_request());
    src_idle_en = 1'b1;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: checks each transfer and stalls at random or for a hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_date_result();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(sink_idle_en && $urandom_range(0, 99) < 8);
      end
    end
  end

  initial begin
    error_count        = 0;
    cycle_count        = 0;
    hold_off_cycles    = 0;
    src_idle_en        = 1'b1;
    sink_idle_en       = 1'b1;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = '0;
    in_if.first_year   = '0;
    in_if.first_month  = '0;
    in_if.first_day    = '0;
    in_if.second_year  = '0;
    in_if.second_month = '0;
    in_if.second_day   = '0;
    in_if.day_offset   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_move_extremes();
    test_difference();
    test_invalid_dates();
    test_backpressure();
    test_random_traffic(70);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/gda_pkg.sv
rtl/gda_in_if.sv
rtl/gda_out_if.sv
rtl/gda_alu.sv
rtl/gregorian_date_arithmetic.sv
rtl/gda_checker.sv
bench/tb_gregorian_date_arithmetic.sv
